// ===== rtl/cmee_pkg.sv =====
// Package for the context-model entropy estimator: constants and sequencer states.
package cmee_pkg;

  localparam int CtxBitsDefault   = 12;
  localparam int StreamsDefault   = 2;
  localparam int CountLimitBits   = 14;
  localparam int ProbFracBits     = 24;

  localparam int EntropyW  = 21;
  localparam int SampleW   = 17;
  localparam int CfgAddrW  = 1;
  localparam int CfgDataW  = 4;

  localparam logic [SampleW-1:0]  WindowLimit = 17'd80000;
  localparam logic [EntropyW-1:0] EntropyMax  = {EntropyW{1'b1}};

  localparam logic [CfgAddrW-1:0] RegCtxBits = 1'd0;
  localparam logic [CfgAddrW-1:0] RegStreams = 1'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_NORM,
    ST_WRITE,
    ST_HALVE_RD,
    ST_HALVE_WR,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/context_model_entropy_estimator_core.sv =====
// Top level of the context-model entropy estimator.
// Per bit: read and load the row, two divider passes, doubling to normalise, write, output;
// a zero count skips the divider. A new bit is taken only when idle with no output pending;
// a halving pass over every row may come before the output.
// Reset (rst_n, synchronous): clears the count store one row per cycle, over all
// MAX_STREAMS * 2^MAX_CONTEXT_BITS rows, while in_tready stays low.
module context_model_entropy_estimator_core #(
  parameter int MAX_CONTEXT_BITS = cmee_pkg::CtxBitsDefault,
  parameter int MAX_STREAMS      = cmee_pkg::StreamsDefault,
  parameter int COUNT_LIMIT_BITS = cmee_pkg::CountLimitBits,
  parameter int PROB_FRAC_BITS   = cmee_pkg::ProbFracBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cmee_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [cmee_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] new_bit
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata   // [20:0] entropy_bits, [37:21] bits_sampled
);
  import cmee_pkg::*;

  localparam int StreamW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int AddrW   = StreamW + MAX_CONTEXT_BITS;
  localparam int Depth   = MAX_STREAMS << MAX_CONTEXT_BITS;
  localparam int CntW    = COUNT_LIMIT_BITS;
  localparam int TotW    = CntW + 1;
  localparam int ProbW   = PROB_FRAC_BITS + 1;
  localparam int DivW    = (ProbW > TotW + CntW) ? ProbW : TotW + CntW;
  localparam int CtxCfgW = $clog2(MAX_CONTEXT_BITS + 1);
  localparam int NsW     = $clog2(MAX_STREAMS + 1);
  localparam logic [ProbW-1:0] ProbOne  = ProbW'(1) << PROB_FRAC_BITS;
  localparam logic [ProbW-1:0] ProbHalf = ProbW'(1) << (PROB_FRAC_BITS - 1);

  // count store: {one count, zero count}
  logic [2*CntW-1:0] mem [Depth];
  logic [2*CntW-1:0] rd_data_r;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [2*CntW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  state_t state_r, state_nxt;
  logic [3:0]               ctx_bits_r;
  logic [1:0]               nstr_r;
  logic [MAX_CONTEXT_BITS-1:0] hist_r, hist_nxt;
  logic                     last_r, last_nxt;
  logic [StreamW-1:0]       sidx_r, sidx_nxt;
  logic [StreamW-1:0]       strm_r, strm_nxt;
  logic [MAX_CONTEXT_BITS-1:0] ctx_r, ctx_nxt;
  logic                     bit_r, bit_nxt;
  logic [ProbW-1:0]         prob_r, prob_nxt;
  logic [EntropyW-1:0]      ent_r, ent_nxt;
  logic [SampleW-1:0]       samp_r, samp_nxt;
  logic [AddrW:0]           sweep_r, sweep_nxt;
  logic [CntW-1:0]          cz_r, cz_nxt, co_r, co_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic [ProbW+CntW-1:0]    acc_r, acc_nxt;
  logic [DivW-1:0]          num_r, num_nxt;
  logic [39:0]              out_data_r, out_data_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // effective configuration
  logic [CtxCfgW-1:0] nbits;
  logic [NsW-1:0]     nstreams;
  always_comb begin
    if (ctx_bits_r == 4'd0) nbits = CtxCfgW'(1);
    else if (32'(ctx_bits_r) > MAX_CONTEXT_BITS) nbits = CtxCfgW'(MAX_CONTEXT_BITS);
    else nbits = CtxCfgW'(ctx_bits_r);
    if (nstr_r == 2'd0) nstreams = NsW'(1);
    else if (32'(nstr_r) > MAX_STREAMS) nstreams = NsW'(MAX_STREAMS);
    else nstreams = NsW'(nstr_r);
  end

  // shared divider: p / total, then (r*c) / total
  logic             div_start, div_done;
  logic [DivW-1:0]  div_num;
  logic [DivW-1:0]  div_q;
  logic [TotW-1:0]  div_r;
  logic [TotW-1:0]  total;
  assign total   = {1'b0, cz_r} + {1'b0, co_r};
  assign div_num = (sweep_r == '0) ? DivW'(prob_r) : num_r;

  cmee_divider #(.NumW(DivW), .DenW(TotW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(total),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  logic [MAX_CONTEXT_BITS-1:0] hist_shift;
  logic [MAX_CONTEXT_BITS-1:0] ctx_mask;
  logic [CntW:0]               inc;
  logic [AddrW-1:0]            cur_addr;
  assign hist_shift = {hist_r[MAX_CONTEXT_BITS-2:0], last_r};
  assign ctx_mask   = MAX_CONTEXT_BITS'(({{(MAX_CONTEXT_BITS){1'b0}}, 1'b1} << nbits) - 1'b1);
  assign inc        = {1'b0, cnt_r} + 1'b1;
  assign cur_addr   = {strm_r, ctx_r};

  always_comb begin
    state_nxt = state_r;
    hist_nxt = hist_r; last_nxt = last_r; sidx_nxt = sidx_r; strm_nxt = strm_r;
    ctx_nxt = ctx_r; bit_nxt = bit_r; prob_nxt = prob_r; ent_nxt = ent_r;
    samp_nxt = samp_r; sweep_nxt = sweep_r; cz_nxt = cz_r; co_nxt = co_r;
    cnt_nxt = cnt_r; acc_nxt = acc_r; num_nxt = num_r;
    out_data_nxt = out_data_r; out_valid_nxt = out_valid_r;
    div_start = 1'b0;
    mem_we = 1'b0; mem_waddr = cur_addr; mem_wdata = '0; mem_raddr = cur_addr;
    in_tready = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[AddrW-1:0];
        mem_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (AddrW+1)'(Depth - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = !out_valid_r;
        if (in_tvalid && in_tready) begin
          strm_nxt = (NsW'(sidx_r) < nstreams) ? sidx_r : '0;
          sidx_nxt = (NsW'(strm_nxt) + 1'b1 < nstreams) ? strm_nxt + 1'b1 : '0;
          hist_nxt = hist_shift;
          last_nxt = in_tdata[0];
          bit_nxt  = in_tdata[0];
          ctx_nxt  = hist_shift & ctx_mask;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        cz_nxt  = rd_data_r[CntW-1:0];
        co_nxt  = rd_data_r[2*CntW-1:CntW];
        cnt_nxt = bit_r ? co_nxt : cz_nxt;
        sweep_nxt = '0;
        state_nxt = (cnt_nxt != '0) ? ST_DIV : ST_NORM;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // q*c first, then (r*c)/t through the divider again
        if (div_done) begin
          if (sweep_r == '0) begin
            acc_nxt   = (ProbW+CntW)'(div_q) * (ProbW+CntW)'(cnt_r);
            num_nxt   = DivW'((TotW+CntW)'(div_r) * (TotW+CntW)'(cnt_r));
            sweep_nxt = (AddrW+1)'(1);
            state_nxt = ST_DIV;
          end else begin
            prob_nxt  = ProbW'(acc_r + (ProbW+CntW)'(div_q));
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (prob_r <= ProbHalf) begin
          prob_nxt = prob_r << 1;
          if (ent_r != EntropyMax) ent_nxt = ent_r + 1'b1;
        end else begin
          samp_nxt  = samp_r + 1'b1;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = bit_r ? {inc[CntW-1:0], cz_r} : {co_r, inc[CntW-1:0]};
        sweep_nxt = '0;
        state_nxt = inc[CntW] ? ST_HALVE_RD : ST_OUT;
      end
      ST_HALVE_RD: begin
        mem_raddr = sweep_r[AddrW-1:0];
        state_nxt = ST_HALVE_WR;
      end
      ST_HALVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[AddrW-1:0];
        mem_wdata = {1'b0, rd_data_r[2*CntW-1:CntW+1], 1'b0, rd_data_r[CntW-1:1]};
        // the row that hit the limit holds a count too wide for the store
        if (sweep_r[AddrW-1:0] == cur_addr)
          mem_wdata = bit_r ? {inc[CntW:1], 1'b0, cz_r[CntW-1:1]}
                            : {1'b0, co_r[CntW-1:1], inc[CntW:1]};
        sweep_nxt = sweep_r + 1'b1;
        state_nxt = (sweep_r == (AddrW+1)'(Depth - 1)) ? ST_OUT : ST_HALVE_RD;
      end
      ST_OUT: begin
        if (samp_r >= WindowLimit) begin
          samp_nxt = samp_r >> 1;
          ent_nxt  = ent_r >> 1;
        end
        out_data_nxt  = {2'b00, samp_nxt, ent_nxt};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ctx_bits_r  <= 4'd12;
      nstr_r      <= 2'd2;
      hist_r      <= '0;
      last_r      <= 1'b0;
      sidx_r      <= '0;
      prob_r      <= ProbOne;
      ent_r       <= '0;
      samp_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      last_r      <= last_nxt;
      sidx_r      <= sidx_nxt;
      prob_r      <= prob_nxt;
      ent_r       <= ent_nxt;
      samp_r      <= samp_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == RegCtxBits) ctx_bits_r <= cfg_wdata;
      if (cfg_we && cfg_addr == RegStreams) nstr_r <= cfg_wdata[1:0];
    end
    strm_r     <= strm_nxt;
    ctx_r      <= ctx_nxt;
    bit_r      <= bit_nxt;
    cz_r       <= cz_nxt;
    co_r       <= co_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    num_r      <= num_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (prob_r > ProbHalf && prob_r <= ProbOne))
    else $error("probability out of range while idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("ready while busy");
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:21] < WindowLimit))
    else $error("sample count beyond window");

endmodule

// ===== rtl/cmee_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module cmee_divider #(
  parameter int NumW = 25,
  parameter int DenW = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot,
  output logic [DenW-1:0] rem
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   r_r, r_nxt;
  logic [DenW-1:0] d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {r_r[DenW-1:0], q_r[NumW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      r_nxt    = '0;
      d_nxt    = den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        if (!diff[DenW]) begin
          r_nxt = diff;
          q_nxt = {q_r[NumW-2:0], 1'b1};
        end else begin
          r_nxt = trial;
          q_nxt = {q_r[NumW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  // quotient and remainder are final once all steps are done
  assign done = busy_r && (cnt_r == '0);
  assign quot = q_r;
  assign rem  = r_r[DenW-1:0];

endmodule
